>>> rtl/i2ctsr_pkg.sv
// Package for the I2C temperature sensor reader: payload structs,
// phase numbers of the read transaction and reset constants.
// No dependencies.
package i2ctsr_pkg;

	localparam int PhaseW = 6;

	typedef logic [PhaseW-1:0] phase_t;

	localparam phase_t PhIdle      = phase_t'(0);
	localparam phase_t PhStart     = phase_t'(1);
	localparam phase_t PhStartLow  = phase_t'(2);
	localparam phase_t PhAddrLast  = phase_t'(18);
	localparam phase_t PhAckLowA   = phase_t'(19);
	localparam phase_t PhAckHighA  = phase_t'(20);
	localparam phase_t PhHighLast  = phase_t'(36);
	localparam phase_t PhAckLow    = phase_t'(37);
	localparam phase_t PhAckHigh   = phase_t'(38);
	localparam phase_t PhLowLast   = phase_t'(54);
	localparam phase_t PhNackLow   = phase_t'(55);
	localparam phase_t PhNackHigh  = phase_t'(56);
	localparam phase_t PhStopLow   = phase_t'(57);
	localparam phase_t PhStopHigh  = phase_t'(58);
	localparam phase_t PhDone      = phase_t'(59);

	localparam logic [7:0] ReadAddressReset = 8'h91;
	localparam logic [7:0] TempOffset       = 8'h80;

	typedef struct packed {
		logic start_request;
		logic sda_in;
	} in_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic       address_acked;
		logic [7:0] raw_high_byte;
		logic [7:0] raw_low_byte;
		logic [7:0] temperature;
	} out_t;

endpackage

>>> rtl/i2ctsr_core.sv
// Transaction sequencer of the I2C temperature sensor reader: phase
// counter, shift register and byte registers, one bus phase per transfer.
// Depends on i2ctsr_pkg.
module i2ctsr_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  i2ctsr_pkg::in_t   in_data,
	input  logic [7:0]        read_address,
	output i2ctsr_pkg::out_t  res
);

	i2ctsr_pkg::phase_t phase_q, p, phase_d;
	logic [2:0] bit_count_q, bit_count_d, bit_inc;
	logic [7:0] shift_q, shift_d, shift_in;
	logic [7:0] high_q, high_d, low_q, low_d;
	logic       ack_q, ack_d;
	logic       scl, sda, drv, busy, done;

	assign bit_inc  = bit_count_q + 3'd1;
	assign shift_in = {shift_q[6:0], in_data.sda_in};

	always_comb begin
		if (phase_q == i2ctsr_pkg::PhIdle) begin
			p = in_data.start_request ? i2ctsr_pkg::PhStart : i2ctsr_pkg::PhIdle;
		end else begin
			p = phase_q + i2ctsr_pkg::phase_t'(1);
		end
		bit_count_d = bit_count_q;
		shift_d     = shift_q;
		high_d      = high_q;
		low_d       = low_q;
		ack_d       = ack_q;
		scl         = 1'b1;
		sda         = 1'b1;
		drv         = 1'b1;
		busy        = (p != i2ctsr_pkg::PhIdle);
		done        = 1'b0;
		priority if (p == i2ctsr_pkg::PhIdle) begin
			scl = 1'b1;
		end else if (p == i2ctsr_pkg::PhStart) begin
			bit_count_d = 3'd0;
			shift_d     = 8'd0;
			ack_d       = 1'b0;
			sda         = 1'b0;
		end else if (p == i2ctsr_pkg::PhStartLow) begin
			scl = 1'b0;
			sda = 1'b0;
		end else if (p <= i2ctsr_pkg::PhAddrLast) begin
			sda = read_address[~bit_count_q];
			scl = ~p[0];
			if (!p[0]) begin
				bit_count_d = bit_inc;
			end
		end else if (p == i2ctsr_pkg::PhAckLowA) begin
			scl = 1'b0;
			drv = 1'b0;
		end else if (p == i2ctsr_pkg::PhAckHighA) begin
			drv   = 1'b0;
			ack_d = ~in_data.sda_in;
		end else if (p <= i2ctsr_pkg::PhHighLast) begin
			drv = 1'b0;
			scl = ~p[0];
			if (!p[0]) begin
				shift_d     = shift_in;
				bit_count_d = bit_inc;
				if (bit_inc == 3'd0) begin
					high_d = shift_in;
				end
			end
		end else if (p == i2ctsr_pkg::PhAckLow) begin
			scl = 1'b0;
			sda = 1'b0;
		end else if (p == i2ctsr_pkg::PhAckHigh) begin
			sda = 1'b0;
		end else if (p <= i2ctsr_pkg::PhLowLast) begin
			drv = 1'b0;
			scl = ~p[0];
			if (!p[0]) begin
				shift_d     = shift_in;
				bit_count_d = bit_inc;
				if (bit_inc == 3'd0) begin
					low_d = shift_in;
				end
			end
		end else if (p == i2ctsr_pkg::PhNackLow) begin
			scl = 1'b0;
		end else if (p == i2ctsr_pkg::PhNackHigh) begin
			scl = 1'b1;
		end else if (p == i2ctsr_pkg::PhStopLow) begin
			scl = 1'b0;
			sda = 1'b0;
		end else if (p == i2ctsr_pkg::PhStopHigh) begin
			sda = 1'b0;
		end else begin
			done = 1'b1;
		end
		phase_d = (p == i2ctsr_pkg::PhDone) ? i2ctsr_pkg::PhIdle : p;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= i2ctsr_pkg::PhIdle;
			bit_count_q <= 3'd0;
			shift_q     <= 8'd0;
			high_q      <= 8'd0;
			low_q       <= 8'd0;
			ack_q       <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_d;
			bit_count_q <= bit_count_d;
			shift_q     <= shift_d;
			high_q      <= high_d;
			low_q       <= low_d;
			ack_q       <= ack_d;
		end
	end

	always_comb begin
		res.scl_level     = scl;
		res.sda_level     = sda;
		res.sda_drive     = drv;
		res.busy_res      = busy;
		res.done_res      = done;
		res.address_acked = ack_d;
		res.raw_high_byte = high_d;
		res.raw_low_byte  = low_d;
		res.temperature   = high_d[7] ? (~high_d + i2ctsr_pkg::TempOffset) : high_d;
	end

endmodule

>>> rtl/i2c_temp_sensor_reader.sv
// Top level of the I2C temperature sensor reader: address register,
// output register and skid stage around the sequencer.
// Depends on i2ctsr_pkg and i2ctsr_core.
//
// Use: every transfer on the input channel is one bus phase tick from an
// outside prescaler; start_request on an idle tick begins a 59-tick read
// (start, address byte, ACK slot, two data bytes, stop). Each input
// transfer yields exactly one output transfer carrying the line levels to
// drive for that tick, busy/done flags, the address ACK and the bytes.
// Each tick's result goes into the output register, or into the skid stage
// while the output stalls; throughput is one transfer per cycle while
// in_stall is low. The output register and a one-entry skid stage let one
// more input be taken while a result waits; in_stall rises only when both
// hold results. Reset empties both, puts the sequencer idle, clears the
// bytes and loads read_address with 0x91. cfg_we writes read_address.
module i2c_temp_sensor_reader (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  i2ctsr_pkg::in_t   in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output i2ctsr_pkg::out_t  out_data,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata
);

	logic              accept, out_free;
	logic [7:0]        read_address_q;
	logic              out_valid_q, skid_valid_q;
	i2ctsr_pkg::out_t  out_q, skid_q, res;

	assign in_stall  = skid_valid_q;
	assign accept    = in_valid && !skid_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	i2ctsr_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.in_data      (in_data),
		.read_address (read_address_q),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_address_q <= i2ctsr_pkg::ReadAddressReset;
		end else if (cfg_we) begin
			read_address_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (accept) begin
			skid_q <= res;
		end
	end

endmodule

>>> dv/tb_i2c_temp_sensor_reader.sv
// Self-checking testbench for i2c_temp_sensor_reader: a directed table, then shaped random
// read transactions under each read address, checked per transfer against a tick predictor.
// Depends on i2ctsr_pkg and the i2c_temp_sensor_reader RTL.
`timescale 1ns / 1ps

module tb_i2c_temp_sensor_reader;

	localparam int CycleLimit = 400000;
	localparam int ItemsPerSetting = 140;

	localparam i2ctsr_pkg::out_t Unchecked   = '0;
	localparam i2ctsr_pkg::out_t ResetIdle   = {3'b111, 3'b000, 24'h000000};
	localparam i2ctsr_pkg::out_t StartOut    = {3'b101, 3'b100, 24'h000000};
	localparam i2ctsr_pkg::out_t StartLowOut = {3'b001, 3'b100, 24'h000000};
	localparam i2ctsr_pkg::out_t AddrMsbLow  = {3'b011, 3'b100, 24'h000000};
	localparam i2ctsr_pkg::out_t AddrMsbHigh = {3'b111, 3'b100, 24'h000000};

	typedef struct packed {
		logic             typed;
		i2ctsr_pkg::in_t  stim;
		i2ctsr_pkg::out_t want;
	} row_t;

	localparam row_t Directed [22] = '{
		{1'b1, 2'b01, ResetIdle},
		{1'b1, 2'b00, ResetIdle},
		{1'b1, 2'b10, StartOut},
		{1'b1, 2'b11, StartLowOut},
		{1'b1, 2'b00, AddrMsbLow},
		{1'b1, 2'b11, AddrMsbHigh},
		{1'b0, 2'b01, Unchecked},
		{1'b0, 2'b10, Unchecked},
		{1'b0, 2'b00, Unchecked},
		{1'b0, 2'b01, Unchecked},
		{1'b0, 2'b11, Unchecked},
		{1'b0, 2'b00, Unchecked},
		{1'b0, 2'b01, Unchecked},
		{1'b0, 2'b00, Unchecked},
		{1'b0, 2'b10, Unchecked},
		{1'b0, 2'b01, Unchecked},
		{1'b0, 2'b00, Unchecked},
		{1'b0, 2'b11, Unchecked},
		{1'b0, 2'b01, Unchecked},
		{1'b0, 2'b00, Unchecked},
		{1'b0, 2'b11, Unchecked},
		{1'b0, 2'b00, Unchecked}
	};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	i2ctsr_pkg::in_t  in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	i2ctsr_pkg::out_t out_data;
	logic             cfg_we = 1'b0;
	logic [7:0]       cfg_wdata = 8'h00;

	i2ctsr_pkg::phase_t phase_q;
	logic [2:0]         bit_q;
	logic [7:0]         shift_q, high_q, low_q, address_q;
	logic               ack_q, scl_q, sda_q, drive_q;

	i2ctsr_pkg::out_t pending_ticks [$];
	int   mismatches = 0;
	int   cycles = 0;
	int   issued = 0;
	int   in_calm = 0;
	int   out_calm = 0;

	i2c_temp_sensor_reader dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	function automatic i2ctsr_pkg::out_t predict_tick(i2ctsr_pkg::in_t x);
		i2ctsr_pkg::phase_t p;
		logic               busy, done;
		i2ctsr_pkg::out_t   r;
		busy = 1'b0;
		done = 1'b0;
		if (phase_q == i2ctsr_pkg::PhIdle || phase_q >= i2ctsr_pkg::PhDone) begin
			p = x.start_request ? i2ctsr_pkg::PhStart : i2ctsr_pkg::PhIdle;
		end else begin
			p = phase_q + i2ctsr_pkg::phase_t'(1);
		end
		if (p == i2ctsr_pkg::PhIdle) begin
			{scl_q, sda_q, drive_q} = 3'b111;
		end else begin
			busy = 1'b1;
			if (p == i2ctsr_pkg::PhStart) begin
				bit_q = 3'd0;
				shift_q = 8'h00;
				ack_q = 1'b0;
				{scl_q, sda_q, drive_q} = 3'b101;
			end else if (p == i2ctsr_pkg::PhStartLow) begin
				{scl_q, sda_q, drive_q} = 3'b001;
			end else if (p <= i2ctsr_pkg::PhAddrLast) begin
				{scl_q, sda_q, drive_q} = {~p[0], address_q[3'd7 - bit_q], 1'b1};
				if (!p[0])
					bit_q = bit_q + 3'd1;
			end else if (p == i2ctsr_pkg::PhAckLowA) begin
				{scl_q, sda_q, drive_q} = 3'b010;
			end else if (p == i2ctsr_pkg::PhAckHighA) begin
				{scl_q, sda_q, drive_q} = 3'b110;
				ack_q = ~x.sda_in;
			end else if (p == i2ctsr_pkg::PhAckLow) begin
				{scl_q, sda_q, drive_q} = 3'b001;
			end else if (p == i2ctsr_pkg::PhAckHigh) begin
				{scl_q, sda_q, drive_q} = 3'b101;
			end else if (p <= i2ctsr_pkg::PhLowLast) begin
				{scl_q, sda_q, drive_q} = {~p[0], 2'b10};
				if (!p[0]) begin
					shift_q = {shift_q[6:0], x.sda_in};
					bit_q = bit_q + 3'd1;
					if (bit_q == 3'd0) begin
						if (p <= i2ctsr_pkg::PhHighLast)
							high_q = shift_q;
						else
							low_q = shift_q;
					end
				end
			end else if (p == i2ctsr_pkg::PhNackLow) begin
				{scl_q, sda_q, drive_q} = 3'b011;
			end else if (p == i2ctsr_pkg::PhNackHigh) begin
				{scl_q, sda_q, drive_q} = 3'b111;
			end else if (p == i2ctsr_pkg::PhStopLow) begin
				{scl_q, sda_q, drive_q} = 3'b001;
			end else if (p == i2ctsr_pkg::PhStopHigh) begin
				{scl_q, sda_q, drive_q} = 3'b101;
			end else begin
				{scl_q, sda_q, drive_q} = 3'b111;
				done = 1'b1;
			end
		end
		phase_q = (p >= i2ctsr_pkg::PhDone) ? i2ctsr_pkg::PhIdle : p;
		r.scl_level     = scl_q;
		r.sda_level     = sda_q;
		r.sda_drive     = drive_q;
		r.busy_res      = busy;
		r.done_res      = done;
		r.address_acked = ack_q;
		r.raw_high_byte = high_q;
		r.raw_low_byte  = low_q;
		r.temperature   = high_q[7] ? ~high_q + i2ctsr_pkg::TempOffset : high_q;
		return r;
	endfunction

	function automatic int pick_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 13);
	endfunction

	function automatic logic [7:0] pick_byte();
		unique case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h7F;
			3: return 8'h80;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic sda_for(i2ctsr_pkg::phase_t p, logic [7:0] hi, logic [7:0] lo,
		logic ack_ok);
		if (p == i2ctsr_pkg::PhAckHighA)
			return ~ack_ok;
		if (p > i2ctsr_pkg::PhAckHighA && p <= i2ctsr_pkg::PhHighLast && !p[0])
			return hi[3'((i2ctsr_pkg::PhHighLast - p) >> 1)];
		if (p > i2ctsr_pkg::PhAckHigh && p <= i2ctsr_pkg::PhLowLast && !p[0])
			return lo[3'((i2ctsr_pkg::PhLowLast - p) >> 1)];
		return 1'($urandom_range(0, 1));
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		mismatches++;
	endtask

	task automatic check_transfer(i2ctsr_pkg::out_t got, i2ctsr_pkg::out_t want);
		if (got.scl_level !== want.scl_level)
			report_mismatch("scl_level", int'(got.scl_level), int'(want.scl_level));
		if (got.sda_level !== want.sda_level)
			report_mismatch("sda_level", int'(got.sda_level), int'(want.sda_level));
		if (got.sda_drive !== want.sda_drive)
			report_mismatch("sda_drive", int'(got.sda_drive), int'(want.sda_drive));
		if (got.busy_res !== want.busy_res)
			report_mismatch("busy_res", int'(got.busy_res), int'(want.busy_res));
		if (got.done_res !== want.done_res)
			report_mismatch("done_res", int'(got.done_res), int'(want.done_res));
		if (got.address_acked !== want.address_acked)
			report_mismatch("address_acked", int'(got.address_acked),
				int'(want.address_acked));
		if (got.raw_high_byte !== want.raw_high_byte)
			report_mismatch("raw_high_byte", int'(got.raw_high_byte),
				int'(want.raw_high_byte));
		if (got.raw_low_byte !== want.raw_low_byte)
			report_mismatch("raw_low_byte", int'(got.raw_low_byte), int'(want.raw_low_byte));
		if (got.temperature !== want.temperature)
			report_mismatch("temperature", int'(got.temperature), int'(want.temperature));
	endtask

	task automatic send_tick(i2ctsr_pkg::in_t x, logic typed, i2ctsr_pkg::out_t want);
		int               gap;
		i2ctsr_pkg::out_t predicted;
		gap = pick_wait(in_calm);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= x;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = predict_tick(x);
		pending_ticks.push_back(typed ? want : predicted);
		issued++;
	endtask

	task automatic read_transaction();
		logic [7:0] hi, lo;
		logic       ack_ok;
		int         idle_ticks;
		hi = pick_byte();
		lo = pick_byte();
		ack_ok = ($urandom_range(0, 4) != 0);
		idle_ticks = $urandom_range(0, 4);
		if (phase_q == i2ctsr_pkg::PhIdle)
			send_tick({1'b1, 1'($urandom_range(0, 1))}, 1'b0, Unchecked);
		while (phase_q != i2ctsr_pkg::PhIdle)
			send_tick({($urandom_range(0, 9) == 0),
				sda_for(phase_q + i2ctsr_pkg::phase_t'(1), hi, lo, ack_ok)}, 1'b0,
				Unchecked);
		repeat (idle_ticks)
			send_tick({1'b0, 1'($urandom_range(0, 1))}, 1'b0, Unchecked);
	endtask

	task automatic run_traffic(int quota);
		int first;
		int burst;
		first = issued;
		while (issued - first < quota) begin
			if ($urandom_range(0, 4) != 0) begin
				read_transaction();
			end else begin
				burst = $urandom_range(5, 30);
				repeat (burst)
					send_tick({($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1))},
						1'b0, Unchecked);
			end
		end
	endtask

	task automatic settle();
		while (phase_q != i2ctsr_pkg::PhIdle)
			send_tick({1'b0, 1'($urandom_range(0, 1))}, 1'b0, Unchecked);
		in_valid <= 1'b0;
		while (pending_ticks.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_address(logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		address_q = value;
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_ticks.size() == 0)
				report_mismatch("transfer with nothing pending", int'(out_data), 0);
			else
				check_transfer(out_data, pending_ticks.pop_front());
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int n;
		forever begin
			n = pick_wait(out_calm);
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!(out_valid && !out_stall)) @(posedge clk);
		end
	end

	initial begin
		phase_q = i2ctsr_pkg::PhIdle;
		bit_q = 3'd0;
		shift_q = 8'h00;
		high_q = 8'h00;
		low_q = 8'h00;
		ack_q = 1'b0;
		{scl_q, sda_q, drive_q} = 3'b111;
		address_q = i2ctsr_pkg::ReadAddressReset;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		foreach (Directed[i])
			send_tick(Directed[i].stim, Directed[i].typed, Directed[i].want);
		run_traffic(ItemsPerSetting);
		settle();
		write_address(8'h00);
		run_traffic(ItemsPerSetting);
		settle();
		write_address(8'hFF);
		run_traffic(ItemsPerSetting);
		settle();
		write_address(8'($urandom));
		run_traffic(ItemsPerSetting);
		settle();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/i2ctsr_pkg.sv
rtl/i2ctsr_core.sv
rtl/i2c_temp_sensor_reader.sv
dv/tb_i2c_temp_sensor_reader.sv
